[sv/icmp_er_pkg.sv]
// Shared types, constants and helper functions for the ICMP echo responder.
package icmp_er_pkg;

  // ICMP type codes that the responder recognizes.
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_UNREACHABLE   = 8'd3;
  localparam logic [7:0] TYPE_ECHO_REQUEST  = 8'd8;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  // Length of the fixed ICMP header in bytes.
  localparam logic [15:0] HDR_BYTES = 16'd8;
  localparam logic [15:0] MASK16    = 16'hFFFF;

  // Verdict codes carried with each result.
  typedef enum logic [2:0] {
    VERDICT_BAD_CSUM   = 3'd0,
    VERDICT_ECHO_REQ   = 3'd1,
    VERDICT_ECHO_REPLY = 3'd2,
    VERDICT_UNREACH    = 3'd3,
    VERDICT_TIME_EXC   = 3'd4,
    VERDICT_UNHANDLED  = 3'd5,
    VERDICT_TOO_SHORT  = 3'd6
  } verdict_e;

  // One request on the input channel: a message byte with its framing.
  typedef struct packed {
    logic [7:0]  msg_byte;
    logic        last_byte;
    logic [31:0] peer_addr;
  } in_req_t;

  // One request on the output channel: the verdict and reply header.
  typedef struct packed {
    verdict_e    verdict;
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [15:0] ident;
    logic [15:0] seq_num;
    logic [15:0] reply_checksum;
    logic [15:0] payload_len;
    logic [31:0] reply_addr;
  } out_req_t;

  // One's-complement 16-bit add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

[sv/icmp_er_parse.sv]
// Per-message state: header capture, running checksum and verdict logic.
module icmp_er_parse
  import icmp_er_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  in_req_t  req_i,
  output out_req_t res_o
);

  logic [15:0] count_q, count_d;
  logic        long_q, long_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  high_q, high_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  code_q, code_d;
  logic [15:0] cks_q, cks_d;
  logic [15:0] ident_q, ident_d;
  logic [15:0] seq_q, seq_d;
  logic [31:0] addr_q, addr_d;

  logic        in_hdr;
  logic        low_hdr;
  logic [15:0] word;
  logic        add_word;
  logic        too_short;
  logic [15:0] calc_cks;
  verdict_e    verdict;
  logic [15:0] reply_cks;
  logic [15:0] payload;

  // Next state for the current byte, before the end-of-message clear.
  always_comb begin
    in_hdr  = !long_q && (count_q < HDR_BYTES);
    low_hdr = in_hdr && (count_q[15:2] == 14'd0);

    type_d  = type_q;
    code_d  = code_q;
    cks_d   = cks_q;
    ident_d = ident_q;
    seq_d   = seq_q;
    addr_d  = addr_q;
    if (in_hdr) begin
      case (count_q[2:0])
        3'd0: begin
          type_d = req_i.msg_byte;
          addr_d = req_i.peer_addr;
        end
        3'd1: code_d = req_i.msg_byte;
        3'd2: cks_d[15:8] = req_i.msg_byte;
        3'd3: cks_d[7:0] = req_i.msg_byte;
        3'd4: ident_d[15:8] = req_i.msg_byte;
        3'd5: ident_d[7:0] = req_i.msg_byte;
        3'd6: seq_d[15:8] = req_i.msg_byte;
        default: seq_d[7:0] = req_i.msg_byte;
      endcase
    end

    // Pair bytes into big-endian words; an odd trailing byte is the high half.
    // The type/code and checksum words stay out of the running sum.
    word     = count_q[0] ? {high_q, req_i.msg_byte} : {req_i.msg_byte, 8'h00};
    add_word = !low_hdr && (count_q[0] || req_i.last_byte);
    sum_d    = add_word ? ones_add(sum_q, word) : sum_q;
    high_d   = count_q[0] ? high_q : req_i.msg_byte;

    count_d = count_q + 16'd1;
    long_d  = long_q || (count_d == 16'd0);
  end

  // Verdict and reply header for a message that ends with this byte.
  always_comb begin
    too_short = !long_d && (count_d < HDR_BYTES);
    if (long_d) begin
      payload = MASK16;
    end else if (too_short) begin
      payload = 16'd0;
    end else begin
      payload = count_d - HDR_BYTES;
    end

    calc_cks  = ~ones_add(sum_d, {type_d, code_d});
    reply_cks = 16'd0;
    if (too_short) begin
      verdict = VERDICT_TOO_SHORT;
    end else if (calc_cks != cks_d) begin
      verdict = VERDICT_BAD_CSUM;
    end else if (type_d == TYPE_ECHO_REQUEST) begin
      verdict   = VERDICT_ECHO_REQ;
      reply_cks = ~sum_d;
    end else if (type_d == TYPE_ECHO_REPLY) begin
      verdict = VERDICT_ECHO_REPLY;
    end else if (type_d == TYPE_UNREACHABLE) begin
      verdict = VERDICT_UNREACH;
    end else if (type_d == TYPE_TIME_EXCEEDED) begin
      verdict = VERDICT_TIME_EXC;
    end else begin
      verdict = VERDICT_UNHANDLED;
    end

    res_o.verdict        = verdict;
    res_o.msg_type       = type_d;
    res_o.msg_code       = code_d;
    res_o.ident          = ident_d;
    res_o.seq_num        = seq_d;
    res_o.reply_checksum = reply_cks;
    res_o.payload_len    = payload;
    res_o.reply_addr     = addr_d;
  end

  // Message state; everything returns to zero after the final byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      long_q  <= 1'b0;
      sum_q   <= '0;
      high_q  <= '0;
      type_q  <= '0;
      code_q  <= '0;
      cks_q   <= '0;
      ident_q <= '0;
      seq_q   <= '0;
      addr_q  <= '0;
    end else if (en_i) begin
      if (req_i.last_byte) begin
        count_q <= '0;
        long_q  <= 1'b0;
        sum_q   <= '0;
        high_q  <= '0;
        type_q  <= '0;
        code_q  <= '0;
        cks_q   <= '0;
        ident_q <= '0;
        seq_q   <= '0;
        addr_q  <= '0;
      end else begin
        count_q <= count_d;
        long_q  <= long_d;
        sum_q   <= sum_d;
        high_q  <= high_d;
        type_q  <= type_d;
        code_q  <= code_d;
        cks_q   <= cks_d;
        ident_q <= ident_d;
        seq_q   <= seq_d;
        addr_q  <= addr_d;
      end
    end
  end

endmodule

[sv/icmp_echo_responder_core.sv]
// Top level of the ICMP echo responder: input register, parser and result register.
//
//   Channel | Direction | Payload    | Handshake
//   in      | input     | in_req_t   | in_valid_i / in_stall_o
//   out     | output    | out_req_t  | out_valid_o / out_stall_i
//
// One byte is taken per cycle unless in_stall_o is raised; a final byte passes from
// the input register through the parser into the result register behind out_valid_o.
// The running one's-complement add in the parser sets the per-byte timing.
// Reset clears all message state; no clearing pass is needed.
// Non-final bytes keep flowing while a result waits; only a final byte stalls
// behind an unaccepted result.
module icmp_echo_responder_core
  import icmp_er_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_data_o
);

  logic     s1_valid_q, s1_valid_d;
  in_req_t  s1_req_q;
  logic     s1_adv;
  logic     in_take;
  logic     res_load;
  out_req_t res_next;
  logic     out_valid_q, out_valid_d;
  out_req_t out_req_q;

  // A held byte moves on unless it ends a message and the result slot is busy.
  assign s1_adv     = !s1_req_q.last_byte || !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;
  assign res_load   = s1_valid_q && s1_adv && s1_req_q.last_byte;

  always_comb begin
    s1_valid_d = in_take || (s1_valid_q && !s1_adv);
    if (res_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  icmp_er_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_valid_q && s1_adv),
    .req_i  (s1_req_q),
    .res_o  (res_next)
  );

  // Control flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q <= in_data_i;
    end
    if (res_load) begin
      out_req_q <= res_next;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_req_q;

endmodule
